FILE: src/kss_pkg.sv
`default_nettype none

package kss_pkg;

  localparam int DEF_STACK_DEPTH = 16;
  localparam int DEF_WORD_WIDTH  = 32;

  localparam int REQ_W    = 3;
  localparam int KEY_W    = 5;
  localparam int STATUS_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_INIT     = 3'd0,
    REQ_PUSH     = 3'd1,
    REQ_POP      = 3'd2,
    REQ_SRCH_VAL = 3'd3,
    REQ_SRCH_KEY = 3'd4,
    REQ_MAX      = 3'd5,
    REQ_CLEAR    = 3'd6
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    status_t          status;
    logic [KEY_W-1:0] position;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] depth;
    logic             last;
  } rsp_meta_t;

endpackage

`default_nettype wire

FILE: src/kss_if.sv
`default_nettype none

interface kss_req_if #(
  parameter int WORD_WIDTH = kss_pkg::DEF_WORD_WIDTH
);
  logic                        valid;
  logic                        ready;
  logic [kss_pkg::REQ_W-1:0]   req_type;
  logic signed [WORD_WIDTH-1:0] value;
  logic [kss_pkg::KEY_W-1:0]   key;

  modport source (output valid, output req_type, output value, output key, input ready);
  modport sink   (input valid, input req_type, input value, input key, output ready);
endinterface

interface kss_rsp_if #(
  parameter int WORD_WIDTH = kss_pkg::DEF_WORD_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic [kss_pkg::STATUS_W-1:0] status;
  logic signed [WORD_WIDTH-1:0] data_out;
  logic [kss_pkg::KEY_W-1:0]    position_out;
  logic [kss_pkg::KEY_W-1:0]    key_out;
  logic [kss_pkg::KEY_W-1:0]    depth_out;
  logic                         last;

  modport source (output valid, output status, output data_out, output position_out,
                  output key_out, output depth_out, output last, input ready);
  modport sink   (input valid, input status, input data_out, input position_out,
                  input key_out, input depth_out, input last, output ready);
endinterface

`default_nettype wire

FILE: src/kss_obuf.sv
`default_nettype none

module kss_obuf #(
  parameter int WORD_WIDTH = kss_pkg::DEF_WORD_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  kss_pkg::rsp_meta_t      meta,
  input  logic [WORD_WIDTH-1:0]   data,
  output logic                    free,
  kss_rsp_if.source               out_chan
);
  import kss_pkg::*;

  logic                  valid_r;
  rsp_meta_t             meta_r;
  logic [WORD_WIDTH-1:0] data_r;

  assign free = !valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      meta_r <= meta;
      data_r <= data;
    end
  end

  assign out_chan.valid        = valid_r;
  assign out_chan.status       = meta_r.status;
  assign out_chan.data_out     = data_r;
  assign out_chan.position_out = meta_r.position;
  assign out_chan.key_out      = meta_r.key;
  assign out_chan.depth_out    = meta_r.depth;
  assign out_chan.last         = meta_r.last;

endmodule

`default_nettype wire

FILE: src/kss_ctrl.sv
`default_nettype none

module kss_ctrl #(
  parameter int STACK_DEPTH = kss_pkg::DEF_STACK_DEPTH,
  parameter int WORD_WIDTH  = kss_pkg::DEF_WORD_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  kss_req_if.sink               in_chan,
  input  logic                  out_free,
  output logic                  out_load,
  output kss_pkg::rsp_meta_t    out_meta,
  output logic [WORD_WIDTH-1:0] out_data
);
  import kss_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int CW = (DW > KEY_W) ? DW : KEY_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POPRD,
    S_KEYRD,
    S_SCAN,
    S_FIN
  } state_t;

  state_t                state_r, state_nxt;
  logic [DW-1:0]         depth_r, depth_nxt;
  logic [DW-1:0]         cnt_r, cnt_nxt;
  logic                  cv_r, cv_nxt;
  logic                  pend_r, pend_nxt;
  logic                  best_v_r, best_v_nxt;
  req_t                  req_r, req_nxt;
  logic [WORD_WIDTH-1:0] val_r, val_nxt;
  logic [KEY_W-1:0]      key_r, key_nxt;
  logic [AW-1:0]         ridx_r, ridx_nxt;
  logic [AW-1:0]         cidx_r, cidx_nxt;
  logic [AW-1:0]         pidx_r, pidx_nxt;
  logic [WORD_WIDTH-1:0] best_r, best_nxt;

  logic [WORD_WIDTH-1:0] mem_a [STACK_DEPTH];
  logic [WORD_WIDTH-1:0] rdata_r;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;

  logic                  match;
  logic                  stall;

  assign in_chan.ready = (state_r == S_IDLE);
  assign match         = cv_r && (rdata_r == val_r);
  assign stall         = (req_r == REQ_SRCH_VAL) && match && pend_r && !out_free;

  always_comb begin
    state_nxt  = state_r;
    depth_nxt  = depth_r;
    cnt_nxt    = cnt_r;
    cv_nxt     = cv_r;
    pend_nxt   = pend_r;
    best_v_nxt = best_v_r;
    req_nxt    = req_r;
    val_nxt    = val_r;
    key_nxt    = key_r;
    ridx_nxt   = ridx_r;
    cidx_nxt   = cidx_r;
    pidx_nxt   = pidx_r;
    best_nxt   = best_r;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    out_load   = 1'b0;
    out_meta   = '0;
    out_data   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          req_nxt   = req_t'(in_chan.req_type);
          val_nxt   = in_chan.value;
          key_nxt   = in_chan.key;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        case (req_r) inside
          REQ_INIT: begin
            if (out_free) begin
              mem_we          = 1'b1;
              mem_waddr       = '0;
              depth_nxt       = DW'(1);
              out_load        = 1'b1;
              out_meta.status = ST_OK;
              out_meta.last   = 1'b1;
              state_nxt       = S_IDLE;
            end
          end
          REQ_PUSH: begin
            if (out_free) begin
              out_load      = 1'b1;
              out_meta.last = 1'b1;
              state_nxt     = S_IDLE;
              if (depth_r == '0) begin
                out_meta.status = ST_EMPTY;
              end else if (depth_r == DW'(STACK_DEPTH)) begin
                out_meta.status = ST_FULL;
              end else begin
                mem_we          = 1'b1;
                mem_waddr       = AW'(depth_r);
                depth_nxt       = depth_r + DW'(1);
                out_meta.status = ST_OK;
              end
            end
          end
          REQ_POP: begin
            if (depth_r == '0) begin
              if (out_free) begin
                out_load        = 1'b1;
                out_meta.status = ST_EMPTY;
                out_meta.last   = 1'b1;
                state_nxt       = S_IDLE;
              end
            end else begin
              mem_re    = 1'b1;
              mem_raddr = AW'(depth_r - DW'(1));
              depth_nxt = depth_r - DW'(1);
              state_nxt = S_POPRD;
            end
          end
          REQ_SRCH_KEY: begin
            if (depth_r == '0) begin
              if (out_free) begin
                out_load        = 1'b1;
                out_meta.status = ST_EMPTY;
                out_meta.last   = 1'b1;
                state_nxt       = S_IDLE;
              end
            end else if (key_r == '0 || CW'(key_r) > CW'(depth_r)) begin
              if (out_free) begin
                out_load        = 1'b1;
                out_meta.status = ST_NOT_FOUND;
                out_meta.last   = 1'b1;
                state_nxt       = S_IDLE;
              end
            end else begin
              mem_re    = 1'b1;
              mem_raddr = AW'(key_r - KEY_W'(1));
              state_nxt = S_KEYRD;
            end
          end
          REQ_SRCH_VAL, REQ_MAX: begin
            if (depth_r == '0) begin
              if (out_free) begin
                out_load        = 1'b1;
                out_meta.status = ST_EMPTY;
                out_meta.last   = 1'b1;
                state_nxt       = S_IDLE;
              end
            end else begin
              mem_re     = 1'b1;
              mem_raddr  = AW'(depth_r - DW'(1));
              cv_nxt     = 1'b1;
              cidx_nxt   = AW'(depth_r - DW'(1));
              cnt_nxt    = depth_r - DW'(1);
              ridx_nxt   = AW'(depth_r - DW'(2));
              pend_nxt   = 1'b0;
              best_v_nxt = 1'b0;
              state_nxt  = S_SCAN;
            end
          end
          REQ_CLEAR: begin
            if (out_free) begin
              out_load        = 1'b1;
              out_meta.status = (depth_r == '0) ? ST_EMPTY : ST_OK;
              out_meta.last   = 1'b1;
              depth_nxt       = '0;
              state_nxt       = S_IDLE;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_POPRD: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_meta.status = ST_OK;
          out_meta.key    = KEY_W'(CW'(depth_r) + CW'(1));
          out_meta.last   = 1'b1;
          out_data        = rdata_r;
          state_nxt       = S_IDLE;
        end
      end

      S_KEYRD: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_meta.status   = ST_OK;
          out_meta.position = KEY_W'(CW'(depth_r) - CW'(key_r) + CW'(1));
          out_meta.key      = key_r;
          out_meta.last     = 1'b1;
          out_data          = rdata_r;
          state_nxt         = S_IDLE;
        end
      end

      S_SCAN: begin
        if (!stall) begin
          if (cv_r) begin
            if (req_r == REQ_SRCH_VAL) begin
              if (match) begin
                if (pend_r) begin
                  out_load          = 1'b1;
                  out_meta.status   = ST_OK;
                  out_meta.position = KEY_W'(CW'(depth_r) - CW'(pidx_r));
                  out_meta.key      = KEY_W'(CW'(pidx_r) + CW'(1));
                  out_data          = val_r;
                end
                pend_nxt = 1'b1;
                pidx_nxt = cidx_r;
              end
            end else if (!best_v_r || $signed(rdata_r) > $signed(best_r)) begin
              best_nxt   = rdata_r;
              best_v_nxt = 1'b1;
            end
          end
          if (cnt_r != '0) begin
            mem_re    = 1'b1;
            mem_raddr = ridx_r;
            ridx_nxt  = ridx_r - AW'(1);
            cnt_nxt   = cnt_r - DW'(1);
            cv_nxt    = 1'b1;
            cidx_nxt  = ridx_r;
          end else begin
            cv_nxt    = 1'b0;
            state_nxt = S_FIN;
          end
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_meta.last = 1'b1;
          state_nxt     = S_IDLE;
          if (req_r == REQ_SRCH_VAL) begin
            if (pend_r) begin
              out_meta.status   = ST_OK;
              out_meta.position = KEY_W'(CW'(depth_r) - CW'(pidx_r));
              out_meta.key      = KEY_W'(CW'(pidx_r) + CW'(1));
              out_data          = val_r;
            end else begin
              out_meta.status = ST_NOT_FOUND;
            end
          end else begin
            out_meta.status = ST_OK;
            out_data        = best_r;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_meta.depth = KEY_W'(depth_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      depth_r  <= '0;
      cnt_r    <= '0;
      cv_r     <= 1'b0;
      pend_r   <= 1'b0;
      best_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      depth_r  <= depth_nxt;
      cnt_r    <= cnt_nxt;
      cv_r     <= cv_nxt;
      pend_r   <= pend_nxt;
      best_v_r <= best_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    val_r  <= val_nxt;
    key_r  <= key_nxt;
    ridx_r <= ridx_nxt;
    cidx_r <= cidx_nxt;
    pidx_r <= pidx_nxt;
    best_r <= best_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_a[mem_waddr] <= val_r;
    end
    if (mem_re) begin
      rdata_r <= mem_a[mem_raddr];
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> state_r == S_EXEC)
    else $error("transfer did not start execution");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(STACK_DEPTH))
    else $error("depth beyond capacity");

  a_write_exec: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r == S_EXEC && out_load)
    else $error("store written outside a completing request");

  a_partial_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && !out_meta.last |-> state_r == S_SCAN && req_r == REQ_SRCH_VAL)
    else $error("non-final result outside value search");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result loaded over a pending transfer");

endmodule

`default_nettype wire

FILE: src/keyed_stack_with_search.sv
// One request at a time: a new request is accepted only after the last result is loaded
// into the output buffer. Init, push, clear and refused requests load their result from
// the execute state; pop and key search read the entry store first. Value search and
// maximum walk the single read port of the entry store one entry a cycle, except while a
// value-search match waits for a free output buffer. Reset empties the stack (depth 0); the
// entry store is not cleared, its contents stay undefined until written.
`default_nettype none

module keyed_stack_with_search #(
  parameter int STACK_DEPTH = kss_pkg::DEF_STACK_DEPTH,
  parameter int WORD_WIDTH  = kss_pkg::DEF_WORD_WIDTH
) (
  input  logic       clk,
  input  logic       rst_n,
  kss_req_if.sink    in_chan,
  kss_rsp_if.source  out_chan
);
  import kss_pkg::*;

  logic                  out_free;
  logic                  out_load;
  rsp_meta_t             out_meta;
  logic [WORD_WIDTH-1:0] out_data;

  kss_ctrl #(
    .STACK_DEPTH (STACK_DEPTH),
    .WORD_WIDTH  (WORD_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_free (out_free),
    .out_load (out_load),
    .out_meta (out_meta),
    .out_data (out_data)
  );

  kss_obuf #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (out_load),
    .meta     (out_meta),
    .data     (out_data),
    .free     (out_free),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire
